### sv/sej_pkg.sv
// Shared constants, command types and the CORDIC angle table for the Jacobi eigen-solver.
`timescale 1ns / 1ps

package sej_pkg;

  localparam int MAX_N = 8;
  localparam int FRAC_BITS = 16;
  localparam int IDX_W = 3;
  localparam int ADDR_W = 2 * IDX_W;
  localparam int DEPTH = MAX_N * MAX_N;
  localparam int DATA_W = 32;
  localparam int CORDIC_STEPS = 30;
  localparam int CORDIC_W = 56;
  localparam int ANG_W = 34;
  localparam int PRESHIFT = 20;
  localparam int ACC_W = 66;

  localparam logic signed [ANG_W-1:0] PI_Q30 = 34'sd3373259426;
  localparam logic signed [CORDIC_W-1:0] CORDIC_GAIN = 56'sd652032874;
  localparam logic signed [DATA_W-1:0] ONE_Q30 = 32'sd1073741824;

  // One product term for the multiply-accumulate unit.
  typedef struct packed {
    logic en;
    logic clr;
    logic neg;
    logic dbl;
    logic signed [DATA_W-1:0] a;
    logic signed [DATA_W-1:0] b;
  } mac_cmd_t;

  // Start request for the CORDIC unit.
  typedef struct packed {
    logic start;
    logic vec;
    logic signed [ANG_W-1:0] x;
    logic signed [ANG_W-1:0] y;
    logic signed [ANG_W-1:0] z;
  } cordic_cmd_t;

  // Result of the CORDIC unit, valid in the cycle that done is high.
  typedef struct packed {
    logic done;
    logic signed [ANG_W-1:0] z;
    logic signed [DATA_W-1:0] c;
    logic signed [DATA_W-1:0] s;
  } cordic_res_t;

  // Arctangent of 2^-idx in Q30 radians.
  function automatic logic signed [ANG_W-1:0] atan_entry(input logic [4:0] idx);
    logic signed [ANG_W-1:0] v;
    case (idx)
      5'd0:  v = 34'sh03243F6A8;
      5'd1:  v = 34'sh01DAC6705;
      5'd2:  v = 34'sh00FADBAFC;
      5'd3:  v = 34'sh007F56EA6;
      5'd4:  v = 34'sh003FEAB76;
      5'd5:  v = 34'sh001FFD55B;
      5'd6:  v = 34'sh000FFFAAA;
      5'd7:  v = 34'sh0007FFF55;
      5'd8:  v = 34'sh0003FFFEA;
      5'd9:  v = 34'sh0001FFFFD;
      5'd10: v = 34'sh0000FFFFF;
      5'd11: v = 34'sh00007FFFF;
      5'd12: v = 34'sh00003FFFF;
      5'd13: v = 34'sh00001FFFF;
      5'd14: v = 34'sh00000FFFF;
      5'd15: v = 34'sh000007FFF;
      5'd16: v = 34'sh000003FFF;
      5'd17: v = 34'sh000001FFF;
      5'd18: v = 34'sh000000FFF;
      5'd19: v = 34'sh0000007FF;
      5'd20: v = 34'sh0000003FF;
      5'd21: v = 34'sh0000001FF;
      5'd22: v = 34'sh0000000FF;
      5'd23: v = 34'sh00000007F;
      5'd24: v = 34'sh00000003F;
      5'd25: v = 34'sh00000001F;
      5'd26: v = 34'sh00000000F;
      5'd27: v = 34'sh000000008;
      5'd28: v = 34'sh000000004;
      5'd29: v = 34'sh000000002;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

### sv/symmetric_eigen_jacobi_top.sv
// The block accepts one transfer per cycle while idle.
// A solve copies the loaded matrix, then for each rotation scans for the pivot, fetches it,
// runs the CORDIC unit for the angle and for its cosine and sine, and rotates the matrix and
// then the vectors; then it delivers the n*n results, waiting while the output stalls.
// The multiply-accumulate and CORDIC units are shared across these steps.
// Reset restores the register defaults; the loaded matrix reads as zero until written.
`timescale 1ns / 1ps

module symmetric_eigen_jacobi_top (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic                action,
  input  logic [2:0]          row,
  input  logic [2:0]          col,
  input  logic signed [31:0]  element_value,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [2:0]          vector_index,
  output logic [2:0]          row_index,
  output logic signed [31:0]  eigenvalue,
  output logic signed [31:0]  vector_element,
  output logic                last,
  input  logic                cfg_write,
  input  logic [1:0]          cfg_index,
  input  logic [30:0]         cfg_data
);

  localparam logic [3:0] ST_IDLE   = 4'd0;
  localparam logic [3:0] ST_COPY   = 4'd1;
  localparam logic [3:0] ST_CHECK  = 4'd2;
  localparam logic [3:0] ST_SCAN   = 4'd3;
  localparam logic [3:0] ST_DECIDE = 4'd4;
  localparam logic [3:0] ST_LOADPQ = 4'd5;
  localparam logic [3:0] ST_ANGLE  = 4'd6;
  localparam logic [3:0] ST_TRIG   = 4'd7;
  localparam logic [3:0] ST_ROT    = 4'd8;
  localparam logic [3:0] ST_DIAG   = 4'd9;
  localparam logic [3:0] ST_EMIT   = 4'd10;

  localparam logic ACT_LOAD  = 1'b0;
  localparam logic ACT_SOLVE = 1'b1;

  localparam logic [1:0] CFG_SIZE = 2'd0;
  localparam logic [1:0] CFG_TOL  = 2'd1;
  localparam logic [1:0] CFG_ITER = 2'd2;

  localparam logic [3:0] N_MAX = 4'(sej_pkg::MAX_N);
  localparam logic [31:0] IDENT = 32'(1) << sej_pkg::FRAC_BITS;

  logic [3:0]  matrix_size;
  logic [30:0] tolerance;
  logic [15:0] max_iterations;

  logic [3:0]  state;
  logic [4:0]  step;
  logic [5:0]  cnt;
  logic [15:0] iter;
  logic [3:0]  n;
  logic [2:0]  si;
  logic [2:0]  sj;
  logic [2:0]  p;
  logic [2:0]  q;
  logic [2:0]  oi;
  logic [2:0]  ek;
  logic [2:0]  ei;
  logic        vec_pass;
  logic [31:0] best;
  logic [31:0] mag;
  logic signed [31:0] app;
  logic signed [31:0] aqq;
  logic signed [31:0] apq;
  logic signed [31:0] ru;
  logic signed [31:0] rv;
  logic signed [31:0] nu;
  logic signed [31:0] nv;
  logic signed [31:0] cc;
  logic signed [31:0] ss;
  logic signed [31:0] mm;
  logic signed [31:0] c_val;
  logic signed [31:0] s_val;
  logic signed [sej_pkg::ANG_W-1:0] angle;

  logic [sej_pkg::DEPTH-1:0] lvalid;
  logic        lvalid_rd;
  logic        l_we;
  logic [31:0] l_rdata;
  logic        w_we;
  logic [sej_pkg::ADDR_W-1:0] w_waddr;
  logic [sej_pkg::ADDR_W-1:0] w_raddr;
  logic [31:0] w_wdata;
  logic [31:0] w_rdata;
  logic        v_we;
  logic [sej_pkg::ADDR_W-1:0] v_waddr;
  logic [sej_pkg::ADDR_W-1:0] v_raddr;
  logic [31:0] v_wdata;
  logic [31:0] v_rdata;
  logic signed [31:0] rot_rd;

  sej_pkg::mac_cmd_t    mac_cmd;
  logic signed [31:0]   mac_sat;
  logic signed [31:0]   mac_unit;
  sej_pkg::cordic_cmd_t cor_cmd;
  sej_pkg::cordic_res_t cor_res;

  logic oi_last;
  logic ek_last;
  logic ei_last;
  logic rot_done;
  logic out_free;
  logic [3:0] n_clamped;

  // Stores and shared arithmetic units.
  sej_ram #(.WIDTH(32), .DEPTH(sej_pkg::DEPTH)) u_loaded (
    .clk(clk), .we(l_we), .waddr({row, col}), .wdata(element_value),
    .raddr(cnt), .rdata(l_rdata)
  );

  sej_ram #(.WIDTH(32), .DEPTH(sej_pkg::DEPTH)) u_work (
    .clk(clk), .we(w_we), .waddr(w_waddr), .wdata(w_wdata),
    .raddr(w_raddr), .rdata(w_rdata)
  );

  sej_ram #(.WIDTH(32), .DEPTH(sej_pkg::DEPTH)) u_vec (
    .clk(clk), .we(v_we), .waddr(v_waddr), .wdata(v_wdata),
    .raddr(v_raddr), .rdata(v_rdata)
  );

  sej_mac u_mac (
    .clk(clk), .rst(rst), .cmd(mac_cmd), .sat(mac_sat), .unit(mac_unit)
  );

  sej_cordic u_cordic (
    .clk(clk), .rst(rst), .cmd(cor_cmd), .res(cor_res)
  );

  // Handshake and loop-end conditions.
  always_comb begin
    in_stall  = (state != ST_IDLE);
    l_we      = in_valid && !in_stall && (action == ACT_LOAD);
    out_free  = !out_valid || !out_stall;
    oi_last   = ({1'b0, oi} == n - 4'd1);
    ek_last   = ({1'b0, ek} == n - 4'd1);
    ei_last   = ({1'b0, ei} == n - 4'd1);
    rot_done  = ((step == 5'd0) && !vec_pass && ((oi == p) || (oi == q))) ||
                (step == (vec_pass ? 5'd9 : 5'd11));
    mag       = w_rdata[31] ? (~w_rdata + 32'd1) : w_rdata;
    rot_rd    = vec_pass ? $signed(v_rdata) : $signed(w_rdata);
    if (matrix_size < 4'd2) begin
      n_clamped = 4'd2;
    end else if (matrix_size > N_MAX) begin
      n_clamped = N_MAX;
    end else begin
      n_clamped = matrix_size;
    end
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      matrix_size    <= N_MAX;
      tolerance      <= 31'd1;
      max_iterations <= 16'd1000;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_SIZE: matrix_size    <= cfg_data[3:0];
        CFG_TOL:  tolerance      <= cfg_data;
        CFG_ITER: max_iterations <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // Entry-written marks for the loaded matrix, read alongside the copy.
  always_ff @(posedge clk) begin
    if (rst) begin
      lvalid <= '0;
    end else if (l_we) begin
      lvalid[{row, col}] <= 1'b1;
    end
    lvalid_rd <= lvalid[cnt];
  end

  // Store addresses and unit commands for each step of the sequencer.
  always_comb begin
    w_we    = 1'b0;
    w_waddr = '0;
    w_wdata = '0;
    w_raddr = '0;
    v_we    = 1'b0;
    v_waddr = '0;
    v_wdata = '0;
    v_raddr = '0;
    mac_cmd = '0;
    cor_cmd = '0;
    case (state)
      ST_COPY: begin
        w_we    = step[0];
        w_waddr = cnt;
        w_wdata = lvalid_rd ? l_rdata : '0;
        v_we    = step[0];
        v_waddr = cnt;
        v_wdata = (cnt[5:3] == cnt[2:0]) ? IDENT : '0;
      end
      ST_SCAN: begin
        w_raddr = {si, sj};
      end
      ST_LOADPQ: begin
        case (step)
          5'd0:    w_raddr = {p, p};
          5'd1:    w_raddr = {q, q};
          default: w_raddr = {p, q};
        endcase
      end
      ST_ANGLE: begin
        cor_cmd.start = (step == 5'd0);
        cor_cmd.vec   = 1'b1;
        cor_cmd.x     = sej_pkg::ANG_W'(aqq) - sej_pkg::ANG_W'(app);
        cor_cmd.y     = sej_pkg::ANG_W'(apq) <<< 1;
      end
      ST_TRIG: begin
        cor_cmd.start = (step == 5'd0);
        cor_cmd.z     = angle >>> 1;
      end
      ST_ROT: begin
        w_raddr = (step == 5'd0) ? {oi, p} : {oi, q};
        v_raddr = w_raddr;
        case (step)
          5'd2: begin
            mac_cmd.en = 1'b1; mac_cmd.clr = 1'b1; mac_cmd.a = c_val; mac_cmd.b = ru;
          end
          5'd3: begin
            mac_cmd.en = 1'b1; mac_cmd.neg = 1'b1; mac_cmd.a = s_val; mac_cmd.b = rv;
          end
          5'd4: begin
            mac_cmd.en = 1'b1; mac_cmd.clr = 1'b1; mac_cmd.a = s_val; mac_cmd.b = ru;
          end
          5'd5: begin
            mac_cmd.en = 1'b1; mac_cmd.a = c_val; mac_cmd.b = rv;
          end
          default: ;
        endcase
        if (vec_pass) begin
          case (step)
            5'd8: begin
              v_we = 1'b1; v_waddr = {oi, p}; v_wdata = nu;
            end
            5'd9: begin
              v_we = 1'b1; v_waddr = {oi, q}; v_wdata = nv;
            end
            default: ;
          endcase
        end else begin
          case (step)
            5'd8: begin
              w_we = 1'b1; w_waddr = {oi, p}; w_wdata = nu;
            end
            5'd9: begin
              w_we = 1'b1; w_waddr = {p, oi}; w_wdata = nu;
            end
            5'd10: begin
              w_we = 1'b1; w_waddr = {oi, q}; w_wdata = nv;
            end
            5'd11: begin
              w_we = 1'b1; w_waddr = {q, oi}; w_wdata = nv;
            end
            default: ;
          endcase
        end
      end
      ST_DIAG: begin
        case (step)
          5'd0: begin
            mac_cmd.en = 1'b1; mac_cmd.clr = 1'b1; mac_cmd.a = c_val; mac_cmd.b = c_val;
          end
          5'd1: begin
            mac_cmd.en = 1'b1; mac_cmd.clr = 1'b1; mac_cmd.a = s_val; mac_cmd.b = s_val;
          end
          5'd2: begin
            mac_cmd.en = 1'b1; mac_cmd.clr = 1'b1; mac_cmd.dbl = 1'b1;
            mac_cmd.a = s_val; mac_cmd.b = c_val;
          end
          5'd5: begin
            mac_cmd.en = 1'b1; mac_cmd.clr = 1'b1; mac_cmd.a = cc; mac_cmd.b = app;
          end
          5'd6: begin
            mac_cmd.en = 1'b1; mac_cmd.neg = 1'b1; mac_cmd.a = mm; mac_cmd.b = apq;
          end
          5'd7: begin
            mac_cmd.en = 1'b1; mac_cmd.a = ss; mac_cmd.b = aqq;
          end
          5'd8: begin
            mac_cmd.en = 1'b1; mac_cmd.clr = 1'b1; mac_cmd.a = ss; mac_cmd.b = app;
          end
          5'd9: begin
            mac_cmd.en = 1'b1; mac_cmd.a = mm; mac_cmd.b = apq;
          end
          5'd10: begin
            mac_cmd.en = 1'b1; mac_cmd.a = cc; mac_cmd.b = aqq;
          end
          5'd13: begin
            w_we = 1'b1; w_waddr = {p, p}; w_wdata = nu;
          end
          5'd14: begin
            w_we = 1'b1; w_waddr = {q, q}; w_wdata = nv;
          end
          5'd15: begin
            w_we = 1'b1; w_waddr = {p, q};
          end
          5'd16: begin
            w_we = 1'b1; w_waddr = {q, p};
          end
          default: ;
        endcase
      end
      ST_EMIT: begin
        w_raddr = {ek, ek};
        v_raddr = {ei, ek};
      end
      default: ;
    endcase
  end

  // Sequencer: copy, scan, rotate until done, then deliver the results.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      step      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (in_valid && (action == ACT_SOLVE)) begin
            n     <= n_clamped;
            cnt   <= '0;
            iter  <= '0;
            step  <= '0;
            state <= ST_COPY;
          end
        end
        ST_COPY: begin
          if (step == 5'd0) begin
            step <= 5'd1;
          end else begin
            step <= '0;
            cnt  <= cnt + 6'd1;
            if (cnt == 6'(sej_pkg::DEPTH - 1)) begin
              state <= ST_CHECK;
            end
          end
        end
        ST_CHECK: begin
          step <= '0;
          ek   <= '0;
          ei   <= '0;
          si   <= '0;
          sj   <= 3'd1;
          p    <= '0;
          q    <= 3'd1;
          best <= '0;
          state <= (iter < max_iterations) ? ST_SCAN : ST_EMIT;
        end
        ST_SCAN: begin
          if (step == 5'd0) begin
            step <= 5'd1;
          end else begin
            step <= '0;
            // First strictly larger magnitude wins.
            if (mag > best) begin
              best <= mag;
              p    <= si;
              q    <= sj;
            end
            if (({1'b0, sj} + 4'd1) < n) begin
              sj <= sj + 3'd1;
            end else if (({1'b0, si} + 4'd2) < n) begin
              si <= si + 3'd1;
              sj <= si + 3'd2;
            end else begin
              state <= ST_DECIDE;
            end
          end
        end
        ST_DECIDE: begin
          step <= '0;
          ek   <= '0;
          ei   <= '0;
          state <= (best < {1'b0, tolerance}) ? ST_EMIT : ST_LOADPQ;
        end
        ST_LOADPQ: begin
          step <= step + 5'd1;
          case (step)
            5'd1: app <= $signed(w_rdata);
            5'd2: aqq <= $signed(w_rdata);
            5'd3: begin
              apq   <= $signed(w_rdata);
              step  <= '0;
              state <= ST_ANGLE;
            end
            default: ;
          endcase
        end
        ST_ANGLE: begin
          if (step == 5'd0) begin
            step <= 5'd1;
          end else if (cor_res.done) begin
            angle <= cor_res.z;
            step  <= '0;
            state <= ST_TRIG;
          end
        end
        ST_TRIG: begin
          if (step == 5'd0) begin
            step <= 5'd1;
          end else if (cor_res.done) begin
            c_val    <= cor_res.c;
            s_val    <= cor_res.s;
            oi       <= '0;
            vec_pass <= 1'b0;
            step     <= '0;
            state    <= ST_ROT;
          end
        end
        ST_ROT: begin
          case (step)
            5'd1: ru <= rot_rd;
            5'd2: rv <= rot_rd;
            5'd5: nu <= mac_sat;
            5'd7: nv <= mac_sat;
            default: ;
          endcase
          if (rot_done) begin
            step <= '0;
            if (oi_last) begin
              oi <= '0;
              if (!vec_pass) begin
                state <= ST_DIAG;
              end else begin
                iter  <= iter + 16'd1;
                state <= ST_CHECK;
              end
            end else begin
              oi <= oi + 3'd1;
            end
          end else begin
            step <= step + 5'd1;
          end
        end
        ST_DIAG: begin
          case (step)
            5'd2:  cc <= mac_sat;
            5'd3:  ss <= mac_sat;
            5'd4:  mm <= mac_unit;
            5'd9:  nu <= mac_sat;
            5'd12: nv <= mac_sat;
            default: ;
          endcase
          if (step == 5'd16) begin
            step     <= '0;
            oi       <= '0;
            vec_pass <= 1'b1;
            state    <= ST_ROT;
          end else begin
            step <= step + 5'd1;
          end
        end
        ST_EMIT: begin
          if (step == 5'd0) begin
            step <= 5'd1;
          end else if (out_free) begin
            out_valid      <= 1'b1;
            vector_index   <= ek;
            row_index      <= ei;
            eigenvalue     <= $signed(w_rdata);
            vector_element <= $signed(v_rdata);
            last           <= ek_last && ei_last;
            step           <= '0;
            if (ei_last) begin
              ei <= '0;
              ek <= ek + 3'd1;
              if (ek_last) begin
                state <= ST_IDLE;
              end
            end else begin
              ei <= ei + 3'd1;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  // The CORDIC unit only reports while the sequencer waits for it.
  assert property (@(posedge clk) disable iff (rst)
    cor_res.done |-> (state == ST_ANGLE || state == ST_TRIG))
    else $error("CORDIC result outside angle or trig phase");

  // The chosen pair is always strictly upper-triangular during a rotation.
  assert property (@(posedge clk) disable iff (rst)
    (state == ST_ROT || state == ST_DIAG) |-> (p < q && {1'b0, q} < n))
    else $error("rotation pair out of order or beyond matrix size");

  // A solve always runs with a size in the supported range.
  assert property (@(posedge clk) disable iff (rst)
    (state != ST_IDLE && state != ST_COPY) |-> (n >= 4'd2 && n <= N_MAX))
    else $error("matrix size out of range during solve");

  // A new result is only presented from the delivery phase.
  assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> ($past(state) == ST_EMIT))
    else $error("result presented outside delivery phase");
`endif

endmodule

### sv/sej_ram.sv
// Generic single-write, single-read RAM with a registered read port.
`timescale 1ns / 1ps

module sej_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### sv/sej_mac.sv
// Shared multiply-accumulate unit with Q30 rounding, saturation and unit clamp.
`timescale 1ns / 1ps

module sej_mac (
  input  logic                                    clk,
  input  logic                                    rst,
  input  sej_pkg::mac_cmd_t                       cmd,
  output logic signed [sej_pkg::DATA_W-1:0]       sat,
  output logic signed [sej_pkg::DATA_W-1:0]       unit
);

  logic signed [2*sej_pkg::DATA_W-1:0] prod;
  logic en_q;
  logic clr_q;
  logic neg_q;
  logic dbl_q;
  logic signed [sej_pkg::ACC_W-1:0] acc;
  logic signed [sej_pkg::ACC_W-1:0] term;
  logic signed [sej_pkg::ACC_W-1:0] base;
  logic signed [sej_pkg::ACC_W-1:0] biased;
  logic signed [sej_pkg::ACC_W-1:0] rnd;

  // The product is registered first, then added into the accumulator.
  always_ff @(posedge clk) begin
    if (rst) begin
      en_q <= 1'b0;
    end else begin
      en_q <= cmd.en;
    end
    prod  <= cmd.a * cmd.b;
    clr_q <= cmd.clr;
    neg_q <= cmd.neg;
    dbl_q <= cmd.dbl;
    if (en_q) begin
      acc <= neg_q ? (base - term) : (base + term);
    end
  end

  always_comb begin
    term = dbl_q ? (sej_pkg::ACC_W'(prod) <<< 1) : sej_pkg::ACC_W'(prod);
    base = clr_q ? '0 : acc;
  end

  // Round to nearest on the Q30 boundary with halves rounded up, then saturate and unit-clamp.
  always_comb begin
    biased = acc + (sej_pkg::ACC_W'(1) <<< 29);
    rnd    = biased >>> 30;
    if (rnd > sej_pkg::ACC_W'(32'sh7FFF_FFFF)) begin
      sat = 32'sh7FFF_FFFF;
    end else if (rnd < -(sej_pkg::ACC_W'(1) <<< 31)) begin
      sat = 32'sh8000_0000;
    end else begin
      sat = rnd[sej_pkg::DATA_W-1:0];
    end
    if (rnd > sej_pkg::ACC_W'(sej_pkg::ONE_Q30)) begin
      unit = sej_pkg::ONE_Q30;
    end else if (rnd < -sej_pkg::ACC_W'(sej_pkg::ONE_Q30)) begin
      unit = -sej_pkg::ONE_Q30;
    end else begin
      unit = rnd[sej_pkg::DATA_W-1:0];
    end
  end

endmodule

### sv/sej_cordic.sv
// Iterative CORDIC unit: vectoring for the rotation angle, rotation for cosine and sine.
`timescale 1ns / 1ps

module sej_cordic (
  input  logic                  clk,
  input  logic                  rst,
  input  sej_pkg::cordic_cmd_t  cmd,
  output sej_pkg::cordic_res_t  res
);

  logic signed [sej_pkg::CORDIC_W-1:0] x;
  logic signed [sej_pkg::CORDIC_W-1:0] y;
  logic signed [sej_pkg::CORDIC_W-1:0] dx;
  logic signed [sej_pkg::CORDIC_W-1:0] dy;
  logic signed [sej_pkg::CORDIC_W-1:0] x_in;
  logic signed [sej_pkg::CORDIC_W-1:0] y_in;
  logic signed [sej_pkg::ANG_W-1:0] z;
  logic signed [sej_pkg::ANG_W-1:0] ang;
  logic [4:0] i;
  logic busy;
  logic vec;
  logic done;
  logic sel;

  // One micro-rotation per cycle; the direction rule differs by mode.
  always_comb begin
    dx   = y >>> i;
    dy   = x >>> i;
    ang  = sej_pkg::atan_entry(i);
    sel  = vec ? ~y[sej_pkg::CORDIC_W-1] : z[sej_pkg::ANG_W-1];
    x_in = sej_pkg::CORDIC_W'(cmd.x);
    y_in = sej_pkg::CORDIC_W'(cmd.y);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      vec  <= 1'b0;
    end else begin
      done <= 1'b0;
      if (cmd.start) begin
        vec <= cmd.vec;
        i   <= '0;
        if (cmd.vec) begin
          if (cmd.y == '0) begin
            // Angle of a vector on the x axis is known at once.
            z    <= cmd.x[sej_pkg::ANG_W-1] ? sej_pkg::PI_Q30 : '0;
            done <= 1'b1;
            busy <= 1'b0;
          end else if (cmd.x[sej_pkg::ANG_W-1]) begin
            // Left half-plane: turn the vector round by pi first.
            x    <= (-x_in) <<< sej_pkg::PRESHIFT;
            y    <= (-y_in) <<< sej_pkg::PRESHIFT;
            z    <= cmd.y[sej_pkg::ANG_W-1] ? -sej_pkg::PI_Q30 : sej_pkg::PI_Q30;
            busy <= 1'b1;
          end else begin
            x    <= x_in <<< sej_pkg::PRESHIFT;
            y    <= y_in <<< sej_pkg::PRESHIFT;
            z    <= '0;
            busy <= 1'b1;
          end
        end else begin
          x    <= sej_pkg::CORDIC_GAIN;
          y    <= '0;
          z    <= cmd.z;
          busy <= 1'b1;
        end
      end else if (busy) begin
        if (sel) begin
          x <= x + dx;
          y <= y - dy;
          z <= z + ang;
        end else begin
          x <= x - dx;
          y <= y + dy;
          z <= z - ang;
        end
        if (i == 5'(sej_pkg::CORDIC_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          i <= i + 5'd1;
        end
      end
    end
  end

  // Cosine and sine are clamped to the unit range.
  always_comb begin
    res.done = done;
    res.z    = z;
    if (x > sej_pkg::CORDIC_W'(sej_pkg::ONE_Q30)) begin
      res.c = sej_pkg::ONE_Q30;
    end else if (x < -sej_pkg::CORDIC_W'(sej_pkg::ONE_Q30)) begin
      res.c = -sej_pkg::ONE_Q30;
    end else begin
      res.c = x[sej_pkg::DATA_W-1:0];
    end
    if (y > sej_pkg::CORDIC_W'(sej_pkg::ONE_Q30)) begin
      res.s = sej_pkg::ONE_Q30;
    end else if (y < -sej_pkg::CORDIC_W'(sej_pkg::ONE_Q30)) begin
      res.s = -sej_pkg::ONE_Q30;
    end else begin
      res.s = y[sej_pkg::DATA_W-1:0];
    end
  end

endmodule

### tb/symmetric_eigen_jacobi_top_test.sv
// Self-checking testbench for the fixed-point Jacobi eigen-solver, with its own predictor.
`timescale 1ns / 1ps

module symmetric_eigen_jacobi_top_test;

  // Action and register codes as the block decodes them.
  typedef enum logic { ACT_LOAD = 1'b0, ACT_SOLVE = 1'b1 } action_e;
  typedef enum logic [1:0] { REG_SIZE = 2'd0, REG_TOL = 2'd1, REG_ITERS = 2'd2 } reg_e;
  typedef enum int { ENT_ITEM, ENT_CFG, ENT_PHASE, ENT_HOLD } entry_kind_e;

  typedef struct {
    entry_kind_e kind;
    action_e act;
    logic [2:0] r;
    logic [2:0] c;
    logic signed [31:0] val;
    reg_e reg_idx;
    logic [30:0] reg_val;
    int idle_pct;
    int stall_pct;
  } entry_t;

  typedef struct {
    logic [2:0] vec_idx;
    logic [2:0] row_idx;
    logic signed [31:0] eig;
    logic signed [31:0] elem;
    logic last_flag;
  } eigen_result_t;

  localparam int QUIET_IDLE = 16;
  localparam int QUIET_END = 100;
  localparam int WATCHDOG_LIMIT = 200000;
  localparam longint PI_Q30 = 64'sd3373259426;
  localparam longint ONE_Q30 = 64'sd1073741824;
  localparam longint GAIN_Q30 = 64'sd652032874;
  localparam longint ATAN_Q30[30] = '{
    'h3243F6A8, 'h1DAC6705, 'h0FADBAFC, 'h07F56EA6, 'h03FEAB76, 'h01FFD55B,
    'h00FFFAAA, 'h007FFF55, 'h003FFFEA, 'h001FFFFD, 'h000FFFFF, 'h0007FFFF,
    'h0003FFFF, 'h0001FFFF, 'h0000FFFF, 'h00007FFF, 'h00003FFF, 'h00001FFF,
    'h00000FFF, 'h000007FF, 'h000003FF, 'h000001FF, 'h000000FF, 'h0000007F,
    'h0000003F, 'h0000001F, 'h0000000F, 'h00000008, 'h00000004, 'h00000002};

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic action = 1'b0;
  logic [2:0] row = '0;
  logic [2:0] col = '0;
  logic signed [31:0] element_value = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [2:0] vector_index;
  logic [2:0] row_index;
  logic signed [31:0] eigenvalue;
  logic signed [31:0] vector_element;
  logic last;
  logic cfg_write = 1'b0;
  logic [1:0] cfg_index = '0;
  logic [30:0] cfg_data = '0;

  symmetric_eigen_jacobi_top DUT (.*);

  always #1 clk = ~clk;

  entry_t pending[$];
  eigen_result_t eigen_expected[$];
  entry_t cur;

  // Predictor state: registers and the three stores.
  logic [3:0] size_reg;
  logic [30:0] tol_reg;
  logic [15:0] iters_reg;
  longint loaded_m[64];
  longint work_m[64];
  longint vec_m[64];

  int idle_pct = 0;
  int stall_pct = 0;
  int quiet = 0;
  int mismatches = 0;
  int loads_done = 0;
  int solves_done = 0;
  int results_checked = 0;

  function automatic longint rnd_q30(longint v);
    return (v + (64'sd1 <<< 29)) >>> 30;
  endfunction

  function automatic longint sat_word(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint unit_clamp(longint v);
    if (v > ONE_Q30) return ONE_Q30;
    if (v < -ONE_Q30) return -ONE_Q30;
    return v;
  endfunction

  // Vectoring CORDIC: angle of (x, y) in Q30 radians.
  function automatic longint cordic_angle(longint y, longint x);
    longint z, dx, dy;
    z = 0;
    if (y == 0) return (x < 0) ? PI_Q30 : 0;
    if (x < 0) begin
      z = (y > 0) ? PI_Q30 : -PI_Q30;
      x = -x;
      y = -y;
    end
    x = x * 64'sd1048576;
    y = y * 64'sd1048576;
    for (int i = 0; i < 30; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y >= 0) begin
        x += dx; y -= dy; z += ATAN_Q30[i];
      end else begin
        x -= dx; y += dy; z -= ATAN_Q30[i];
      end
    end
    return z;
  endfunction

  // Rotation CORDIC: cosine and sine of z, clamped to the unit range.
  task automatic cordic_cos_sin(input longint z, output longint cv, output longint sv);
    longint x, y, dx, dy;
    x = GAIN_Q30;
    y = 0;
    for (int i = 0; i < 30; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= ATAN_Q30[i];
      end else begin
        x += dx; y -= dy; z += ATAN_Q30[i];
      end
    end
    cv = unit_clamp(x);
    sv = unit_clamp(y);
  endtask

  // Full solve: copy, iterate rotations, then queue the n*n eigenpair elements.
  task automatic predict_solve();
    int n, p, q;
    logic [31:0] best, mag;
    longint e, app, aqq, apq, cv, sv, cc, ss, m, u, v;
    eigen_result_t res;
    n = size_reg;
    if (n < 2) n = 2;
    if (n > 8) n = 8;
    for (int i = 0; i < 64; i++) begin
      work_m[i] = loaded_m[i];
      vec_m[i] = ((i / 8) == (i % 8)) ? 64'sd65536 : 0;
    end
    for (int it = 0; it < iters_reg; it++) begin
      best = 0;
      p = 0;
      q = 1;
      for (int i = 0; i < n; i++)
        for (int j = i + 1; j < n; j++) begin
          e = work_m[i*8+j];
          mag = 32'((e < 0) ? -e : e);
          if (mag > best) begin
            best = mag; p = i; q = j;
          end
        end
      if (best < {1'b0, tol_reg}) break;
      app = work_m[p*8+p];
      aqq = work_m[q*8+q];
      apq = work_m[p*8+q];
      cordic_cos_sin(cordic_angle(2 * apq, aqq - app) >>> 1, cv, sv);
      for (int i = 0; i < n; i++)
        if (i != p && i != q) begin
          u = work_m[i*8+p];
          v = work_m[i*8+q];
          work_m[i*8+p] = sat_word(rnd_q30(cv * u - sv * v));
          work_m[p*8+i] = work_m[i*8+p];
          work_m[i*8+q] = sat_word(rnd_q30(sv * u + cv * v));
          work_m[q*8+i] = work_m[i*8+q];
        end
      cc = rnd_q30(cv * cv);
      ss = rnd_q30(sv * sv);
      m = unit_clamp(rnd_q30(2 * sv * cv));
      work_m[p*8+p] = sat_word(rnd_q30(cc * app - m * apq + ss * aqq));
      work_m[q*8+q] = sat_word(rnd_q30(ss * app + m * apq + cc * aqq));
      work_m[p*8+q] = 0;
      work_m[q*8+p] = 0;
      for (int i = 0; i < n; i++) begin
        u = vec_m[i*8+p];
        v = vec_m[i*8+q];
        vec_m[i*8+p] = sat_word(rnd_q30(cv * u - sv * v));
        vec_m[i*8+q] = sat_word(rnd_q30(sv * u + cv * v));
      end
    end
    for (int k = 0; k < n; k++)
      for (int i = 0; i < n; i++) begin
        res.vec_idx = 3'(k);
        res.row_idx = 3'(i);
        res.eig = 32'(work_m[k*8+k]);
        res.elem = 32'(vec_m[i*8+k]);
        res.last_flag = (k == n - 1) && (i == n - 1);
        eigen_expected.push_back(res);
      end
  endtask

  // Driver: presents queued items, register writes and phase changes.
  always @(posedge clk) begin
    logic nxt_valid, nxt_write, hold_item;
    if (rst) begin
      in_valid <= 1'b0;
      cfg_write <= 1'b0;
      quiet <= 0;
      size_reg = 4'd8;
      tol_reg = 31'd1;
      iters_reg = 16'd1000;
      for (int i = 0; i < 64; i++) loaded_m[i] = 0;
    end else begin
      nxt_write = 1'b0;
      hold_item = in_valid && in_stall;
      nxt_valid = hold_item;
      if (in_valid && !in_stall) begin
        if (action == ACT_LOAD) begin
          loaded_m[row*8+col] = element_value;
          loads_done++;
        end else begin
          predict_solve();
          solves_done++;
        end
      end
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet <= 0;
      else quiet <= quiet + 1;
      if (!hold_item && pending.size() > 0) begin
        cur = pending[0];
        case (cur.kind)
          ENT_PHASE: begin
            idle_pct = cur.idle_pct;
            stall_pct = cur.stall_pct;
            void'(pending.pop_front());
          end
          ENT_HOLD: begin
            if (!in_valid && quiet >= QUIET_IDLE && eigen_expected.size() == 0)
              void'(pending.pop_front());
          end
          ENT_CFG: begin
            if (!in_valid && quiet >= QUIET_IDLE && eigen_expected.size() == 0) begin
              nxt_write = 1'b1;
              cfg_index <= cur.reg_idx;
              cfg_data <= cur.reg_val;
              case (cur.reg_idx)
                REG_SIZE: size_reg = cur.reg_val[3:0];
                REG_TOL: tol_reg = cur.reg_val;
                default: iters_reg = cur.reg_val[15:0];
              endcase
              void'(pending.pop_front());
            end
          end
          default: begin
            if ($urandom_range(99) >= idle_pct) begin
              nxt_valid = 1'b1;
              action <= cur.act;
              row <= cur.r;
              col <= cur.c;
              element_value <= cur.val;
              void'(pending.pop_front());
            end
          end
        endcase
      end
      in_valid <= nxt_valid;
      cfg_write <= nxt_write;
    end
  end

  // Monitor: random back-pressure and field-by-field checking of each transfer.
  always @(posedge clk) begin
    eigen_result_t exp_r;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        results_checked++;
        if (eigen_expected.size() == 0) begin
          $error("unexpected result transfer: vector_index %0d row_index %0d",
                 vector_index, row_index);
          mismatches++;
        end else begin
          exp_r = eigen_expected.pop_front();
          if (vector_index !== exp_r.vec_idx) begin
            $error("vector_index: expected %0d, got %0d", exp_r.vec_idx, vector_index);
            mismatches++;
          end
          if (row_index !== exp_r.row_idx) begin
            $error("row_index: expected %0d, got %0d", exp_r.row_idx, row_index);
            mismatches++;
          end
          if (eigenvalue !== exp_r.eig) begin
            $error("eigenvalue: expected %0d, got %0d", exp_r.eig, eigenvalue);
            mismatches++;
          end
          if (vector_element !== exp_r.elem) begin
            $error("vector_element: expected %0d, got %0d", exp_r.elem, vector_element);
            mismatches++;
          end
          if (last !== exp_r.last_flag) begin
            $error("last: expected %0d, got %0d", exp_r.last_flag, last);
            mismatches++;
          end
        end
      end
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // Watchdog: ends the run if nothing moves for too long.
  always @(posedge clk) begin
    if (!rst) begin
      if (quiet >= WATCHDOG_LIMIT) begin
        $display("watchdog expired with %0d results outstanding", eigen_expected.size());
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  // An entry with every field at a neutral value.
  function automatic entry_t blank_entry();
    entry_t e;
    e.kind = ENT_ITEM;
    e.act = ACT_LOAD;
    e.r = '0;
    e.c = '0;
    e.val = '0;
    e.reg_idx = REG_SIZE;
    e.reg_val = '0;
    e.idle_pct = 0;
    e.stall_pct = 0;
    return e;
  endfunction

  task automatic add_item(action_e a, int r, int c, logic signed [31:0] v);
    entry_t e;
    e = blank_entry();
    e.kind = ENT_ITEM;
    e.act = a;
    e.r = 3'(r);
    e.c = 3'(c);
    e.val = v;
    pending.push_back(e);
  endtask

  task automatic add_cfg(reg_e idx, longint v);
    entry_t e;
    e = blank_entry();
    e.kind = ENT_CFG;
    e.reg_idx = idx;
    e.reg_val = 31'(v);
    pending.push_back(e);
  endtask

  task automatic add_ctrl(entry_kind_e k, int idle, int stall);
    entry_t e;
    e = blank_entry();
    e.kind = k;
    e.idle_pct = idle;
    e.stall_pct = stall;
    pending.push_back(e);
  endtask

  // Symmetric pair load, the common well-formed case.
  task automatic add_pair(int r, int c, logic signed [31:0] v);
    add_item(ACT_LOAD, r, c, v);
    if (r != c) add_item(ACT_LOAD, c, r, v);
  endtask

  function automatic logic signed [31:0] rand_value();
    int pick;
    pick = $urandom_range(9);
    if (pick < 2) return $urandom();
    if (pick == 2) return ($urandom_range(1)) ? 32'sh7FFFFFFF : 32'sh80000000;
    if (pick == 3) return 0;
    return $signed($urandom_range(32'h7FFFF)) - 32'sd262144;
  endfunction

  // Stimulus plan and end-of-run handling.
  initial begin
    int total, sets, n;
    total = 0;
    sets = 0;

    // Directed part: extremes, unsymmetric input and entries beyond the size in use.
    add_ctrl(ENT_PHASE, 0, 0);
    add_cfg(REG_SIZE, 3);
    add_cfg(REG_TOL, 1);
    add_cfg(REG_ITERS, 8);
    add_item(ACT_LOAD, 0, 0, 32'sh7FFFFFFF);
    add_item(ACT_LOAD, 1, 1, 32'sh80000000);
    add_item(ACT_LOAD, 2, 2, 32'sh00010000);
    add_pair(0, 1, 32'sh00020000);
    add_pair(0, 2, -32'sh00030000);
    add_item(ACT_LOAD, 1, 2, 32'sh00008000);
    add_item(ACT_LOAD, 2, 1, -32'sh00008000);
    add_item(ACT_LOAD, 7, 7, 32'sh00012345);
    add_item(ACT_SOLVE, 0, 0, 0);
    // No iterations: loaded diagonal and identity come straight back.
    add_cfg(REG_ITERS, 0);
    add_item(ACT_SOLVE, 7, 7, 32'shFFFFFFFF);
    // Size below range with zero tolerance and a zero off-diagonal.
    add_cfg(REG_SIZE, 1);
    add_cfg(REG_TOL, 0);
    add_cfg(REG_ITERS, 3);
    add_pair(0, 1, 0);
    add_item(ACT_SOLVE, 0, 0, 0);
    // Size above range, largest tolerance and iteration limit: stops at once.
    add_cfg(REG_SIZE, 15);
    add_cfg(REG_TOL, 31'h7FFFFFFF);
    add_cfg(REG_ITERS, 16'hFFFF);
    add_item(ACT_SOLVE, 0, 0, 0);
    add_cfg(REG_SIZE, 9);
    add_cfg(REG_ITERS, 2);
    add_item(ACT_SOLVE, 0, 0, 0);
    add_ctrl(ENT_HOLD, 0, 0);

    // Random part: mostly symmetric matrices of small size, some noise loads.
    while (total < 270) begin
      case ((total * 4) / 270)
        0: add_ctrl(ENT_PHASE, 0, 0);
        1: add_ctrl(ENT_PHASE, 72, 0);
        2: add_ctrl(ENT_PHASE, 0, 72);
        default: add_ctrl(ENT_PHASE, 35, 35);
      endcase
      if (sets == 6) add_ctrl(ENT_HOLD, 0, 0);
      n = ($urandom_range(5) == 0) ? 8 : $urandom_range(2, 5);
      add_cfg(REG_SIZE, n);
      if ($urandom_range(2) == 0)
        add_cfg(REG_TOL, ($urandom_range(3) == 0) ? 31'($urandom()) : $urandom_range(1, 64));
      add_cfg(REG_ITERS, $urandom_range(0, (n == 8) ? 12 : 40));
      for (int i = 0; i < n; i++)
        for (int j = i; j < n; j++)
          if ($urandom_range(9) < 7) begin
            add_pair(i, j, rand_value());
            total += (i == j) ? 1 : 2;
          end
      for (int k = $urandom_range(2); k > 0; k--) begin
        add_item(ACT_LOAD, $urandom_range(7), $urandom_range(7), $urandom());
        total++;
      end
      add_item(ACT_SOLVE, $urandom_range(7), $urandom_range(7), $urandom());
      total++;
      sets++;
    end

    @(negedge rst);
    forever begin
      @(posedge clk);
      if (pending.size() == 0 && !in_valid && eigen_expected.size() == 0 &&
          quiet >= QUIET_END) break;
    end
    $display("Covered %0d load transfers and %0d solves, %0d results checked,",
             loads_done, solves_done, results_checked);
    $display("over sizes 2 to 8, extreme registers and four idle/stall phases.");
    if (mismatches == 0 && eigen_expected.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // Reset held at the start of the run.
  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
  end

endmodule
